// ===== sv/sha1mh_pkg.sv =====
package sha1mh_pkg;

   localparam logic [31:0] IV_WORDS [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

   localparam logic [5:0] FILL_LAST    = 6'd63;
   localparam logic [5:0] FILL_LEN_POS = 6'd56;

   localparam logic [6:0] ROUND_F1_START = 7'd20;
   localparam logic [6:0] ROUND_F2_START = 7'd40;
   localparam logic [6:0] ROUND_F3_START = 7'd60;
   localparam logic [6:0] ROUND_LAST     = 7'd79;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_COMP     = 7'b0000010,
      ST_FOLD     = 7'b0000100,
      ST_PAD_MARK = 7'b0001000,
      ST_PAD_ZERO = 7'b0010000,
      ST_LEN      = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      SRC_DATA = 2'd0,
      SRC_MARK = 2'd1,
      SRC_ZERO = 2'd2,
      SRC_LEN  = 2'd3
   } byte_src_type;

   typedef struct packed {
      logic         shift;
      byte_src_type src;
      logic         count;
      logic         rot_len;
      logic         load_work;
      logic         round;
      logic         fold;
      logic         emit;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic pad_done;
      logic round_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== sv/sha1mh_ctrl.sv =====
module sha1mh_ctrl
   import sha1mh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      cmd           = '0;
      cmd.src       = SRC_DATA;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_byte_present) begin
                  cmd.shift = 1'b1;
                  cmd.src   = SRC_DATA;
                  cmd.count = 1'b1;
                  if (stat.fill_last) begin
                     cmd.load_work = 1'b1;
                     state_in      = ST_COMP;
                     ret_in        = req_end_of_message ? ST_PAD_MARK : ST_IDLE;
                  end else if (req_end_of_message) begin
                     state_in = ST_PAD_MARK;
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_PAD_MARK: begin
            cmd.shift = 1'b1;
            cmd.src   = SRC_MARK;
            state_in  = ST_PAD_ZERO;
            if (stat.fill_last) begin
               cmd.load_work = 1'b1;
               state_in      = ST_COMP;
               ret_in        = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (stat.pad_done) begin
               state_in = ST_LEN;
            end else begin
               cmd.shift = 1'b1;
               cmd.src   = SRC_ZERO;
               if (stat.fill_last) begin
                  cmd.load_work = 1'b1;
                  state_in      = ST_COMP;
                  ret_in        = ST_PAD_ZERO;
               end
            end
         end
         ST_LEN: begin
            cmd.shift   = 1'b1;
            cmd.src     = SRC_LEN;
            cmd.rot_len = 1'b1;
            if (stat.fill_last) begin
               cmd.load_work = 1'b1;
               state_in      = ST_COMP;
               ret_in        = ST_EMIT;
            end
         end
         ST_COMP: begin
            cmd.round = 1'b1;
            if (stat.round_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ret_ff;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

// ===== sv/sha1mh_dpath.sv =====
module sha1mh_dpath
   import sha1mh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_h0,
   output logic [31:0] rsp_digest_h1,
   output logic [31:0] rsp_digest_h2,
   output logic [31:0] rsp_digest_h3,
   output logic [31:0] rsp_digest_h4
);

   // block / schedule window, word 0 in the top bits
   logic [511:0] blk_ff, blk_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bitcnt_ff, bitcnt_in;
   logic [6:0]   round_ff, round_in;
   logic [31:0]  h_ff [5];
   logic [31:0]  h_in [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [31:0]  out_ff [5];
   logic [31:0]  out_in [5];
   logic         rsp_valid_ff, rsp_valid_in;

   logic [7:0]   byte_sel;
   logic [31:0]  w0, w2, w8, w13, wx, wnew;
   logic [31:0]  fv, kv, tv;

   assign w0   = blk_ff[511:480];
   assign w2   = blk_ff[447:416];
   assign w8   = blk_ff[255:224];
   assign w13  = blk_ff[95:64];
   assign wx   = w13 ^ w8 ^ w2 ^ w0;
   assign wnew = {wx[30:0], wx[31]};

   always_comb begin
      case (cmd.src)
         SRC_DATA: byte_sel = req_data_byte;
         SRC_MARK: byte_sel = PAD_MARK_BYTE;
         SRC_ZERO: byte_sel = 8'h00;
         SRC_LEN:  byte_sel = bitcnt_ff[63:56];
         default:  byte_sel = 8'h00;
      endcase
   end

   always_comb begin
      if (round_ff < ROUND_F1_START) begin
         fv = d_ff ^ (b_ff & (c_ff ^ d_ff));
         kv = K_ROUND0;
      end else if (round_ff < ROUND_F2_START) begin
         fv = b_ff ^ c_ff ^ d_ff;
         kv = K_ROUND1;
      end else if (round_ff < ROUND_F3_START) begin
         fv = (b_ff & c_ff) | (d_ff & (b_ff | c_ff));
         kv = K_ROUND2;
      end else begin
         fv = b_ff ^ c_ff ^ d_ff;
         kv = K_ROUND3;
      end
      tv = {a_ff[26:0], a_ff[31:27]} + fv + e_ff + w0 + kv;
   end

   always_comb begin
      blk_in       = blk_ff;
      fill_in      = fill_ff;
      bitcnt_in    = bitcnt_ff;
      round_in     = round_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      h_in         = h_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.shift) begin
         blk_in  = {blk_ff[503:0], byte_sel};
         fill_in = fill_ff + 6'd1;
      end else if (cmd.round) begin
         blk_in = {blk_ff[479:0], wnew};
      end

      if (cmd.count) begin
         bitcnt_in = bitcnt_ff + 64'd8;
      end else if (cmd.rot_len) begin
         bitcnt_in = {bitcnt_ff[55:0], bitcnt_ff[63:56]};
      end

      if (cmd.load_work) begin
         a_in = h_ff[0];
         b_in = h_ff[1];
         c_in = h_ff[2];
         d_in = h_ff[3];
         e_in = h_ff[4];
      end else if (cmd.round) begin
         a_in     = tv;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
         round_in = (round_ff == ROUND_LAST) ? 7'd0 : round_ff + 7'd1;
      end

      if (cmd.fold) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end

      if (cmd.emit) begin
         out_in       = h_ff;
         h_in         = IV_WORDS;
         fill_in      = '0;
         bitcnt_in    = '0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         bitcnt_ff    <= '0;
         round_ff     <= '0;
         h_ff         <= IV_WORDS;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         bitcnt_ff    <= bitcnt_in;
         round_ff     <= round_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      out_ff <= out_in;
   end

   assign stat.fill_last  = (fill_ff == FILL_LAST);
   assign stat.pad_done   = (fill_ff == FILL_LEN_POS);
   assign stat.round_last = (round_ff == ROUND_LAST);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_digest_h0 = out_ff[0];
   assign rsp_digest_h1 = out_ff[1];
   assign rsp_digest_h2 = out_ff[2];
   assign rsp_digest_h3 = out_ff[3];
   assign rsp_digest_h4 = out_ff[4];

endmodule

// ===== sv/sha1_message_hasher.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | data_byte, byte_present, end_of_message
// rsp     | out       | rsp_valid/rsp_stall  | digest_h0 .. digest_h4
//
// An item is taken while req_stall is low; the byte that fills a 64-byte block starts
// 80 rounds of the single round unit plus the chaining add, with req_stall held high.
// Ending a message feeds padding and length one byte per cycle, paused while a block
// compresses; one or two compressions run before the digest is registered.
// Reset is synchronous; it loads the initial hash values and clears counts.
// A stalled digest waits in the output register while the next message streams in.
module sha1_message_hasher
   import sha1mh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_h0,
   output logic [31:0] rsp_digest_h1,
   output logic [31:0] rsp_digest_h2,
   output logic [31:0] rsp_digest_h3,
   output logic [31:0] rsp_digest_h4
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sha1mh_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .stat               (stat),
      .cmd                (cmd)
   );

   sha1mh_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_digest_h0 (rsp_digest_h0),
      .rsp_digest_h1 (rsp_digest_h1),
      .rsp_digest_h2 (rsp_digest_h2),
      .rsp_digest_h3 (rsp_digest_h3),
      .rsp_digest_h4 (rsp_digest_h4)
   );

endmodule
